// ===== sv/abg_pkg.sv =====
// Shared types, constants and helpers for the alpha-beta-gamma tracker.
`default_nettype none

package abg_pkg;

	// Sub-steps run per measured sample
	localparam int SUB_STEPS = 10;
	localparam int SUB_W     = (SUB_STEPS > 1) ? $clog2(SUB_STEPS) : 1;

	// Configuration port geometry: 64-bit data, registers at 8-byte spacing
	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	// Register indexes (paddr[5:3])
	localparam logic [2:0] REG_ALPHA = 3'd0;
	localparam logic [2:0] REG_BETA  = 3'd1;
	localparam logic [2:0] REG_GAMMA = 3'd2;
	localparam logic [2:0] REG_STEP  = 3'd3;
	localparam logic [2:0] REG_HSS   = 3'd4;

	// Register reset values
	localparam logic [39:0] ALPHA_RST = 40'd17760;
	localparam logic [39:0] BETA_RST  = 40'd3735552;
	localparam logic [39:0] GAMMA_RST = 40'd262144000;
	localparam logic [31:0] STEP_RST  = 32'd2147484;
	localparam logic [47:0] HSS_RST   = 48'd35184372;

	// Saturation limits in the wide finalize domain
	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

	// Gain/interval registers as seen by the datapath
	typedef struct packed {
		logic [39:0] alpha;
		logic [39:0] beta;
		logic [39:0] gamma;
		logic [31:0] step;
		logic [47:0] hss;
	} cfg_t;

	// One multiply-accumulate term of a sub-step
	typedef enum logic [2:0] {
		T_POS    = 3'd0,  // est_pos = pred_pos + alpha*err
		T_VEL    = 3'd1,  // est_vel = pred_vel + beta*err
		T_ACC    = 3'd2,  // est_acc = pred_acc + gamma*err
		T_NPOS_V = 3'd3,  // partial = est_pos + step*est_vel
		T_NPOS_A = 3'd4,  // pred_pos = partial + hss*est_acc
		T_NVEL   = 3'd5   // pred_vel = est_vel + step*est_acc
	} term_t;

	// Sequencer to datapath controls
	typedef struct packed {
		logic  load_meas;
		logic  err_en;
		logic  mul_hi;
		term_t mul_term;
		logic  sum_load;
		logic  sum_add;
		logic  fin_en;
		term_t fin_term;
		logic  out_load;
	} ctrl_t;

	// Clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[31:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/alpha_beta_gamma_tracker.sv =====
// Top level of the fading-memory alpha-beta-gamma position tracker.
//
//   channel  | handshake            | beat contents
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_stall  | measured_position
//   out      | out_valid / out_stall| estimated_position/velocity, predicted_*
//   config   | APB psel/penable     | gains and intervals, 64-bit at 8*index
//
// The result turns valid after ten sub-steps (an error step plus six terms on the
// shared multiplier and accumulator) and the wrap-up and done states. A new input
// beat is taken only once the sequencer is back in idle, so one sample is finished
// before the next is accepted.
// in_stall is high from the accepted beat until the result is registered; a
// stalled output holds the sequencer in its done state. Reset zeroes the
// position, velocity and acceleration state and loads the default gains.
`default_nettype none

module alpha_beta_gamma_tracker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [31:0]           measured_position,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [31:0]                estimated_position,
	output logic signed [31:0]                estimated_velocity,
	output logic signed [31:0]                predicted_position,
	output logic signed [31:0]                predicted_velocity,
	output logic signed [31:0]                predicted_acceleration,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [abg_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [abg_pkg::PDATA_W-1:0]  pwdata,
	output logic      [abg_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);
	import abg_pkg::*;

	cfg_t  cfg;
	ctrl_t ctrl;

	abg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	abg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	abg_dp u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg                    (cfg),
		.ctrl                   (ctrl),
		.measured_position      (measured_position),
		.estimated_position     (estimated_position),
		.estimated_velocity     (estimated_velocity),
		.predicted_position     (predicted_position),
		.predicted_velocity     (predicted_velocity),
		.predicted_acceleration (predicted_acceleration)
	);

endmodule

`default_nettype wire

// ===== sv/abg_regs.sv =====
// APB-style configuration registers for the tracker gains and intervals.
`default_nettype none

module abg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [abg_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [abg_pkg::PDATA_W-1:0]  pwdata,
	output logic      [abg_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	output abg_pkg::cfg_t                     cfg
);
	import abg_pkg::*;

	logic [39:0] alpha_q;
	logic [39:0] beta_q;
	logic [39:0] gamma_q;
	logic [31:0] step_q;
	logic [47:0] hss_q;
	logic [2:0]  idx;
	logic        wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes, bits above each width dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			beta_q  <= BETA_RST;
			gamma_q <= GAMMA_RST;
			step_q  <= STEP_RST;
			hss_q   <= HSS_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ALPHA: alpha_q <= pwdata[39:0];
				REG_BETA:  beta_q  <= pwdata[39:0];
				REG_GAMMA: gamma_q <= pwdata[39:0];
				REG_STEP:  step_q  <= pwdata[31:0];
				REG_HSS:   hss_q   <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_ALPHA: prdata = {24'd0, alpha_q};
			REG_BETA:  prdata = {24'd0, beta_q};
			REG_GAMMA: prdata = {24'd0, gamma_q};
			REG_STEP:  prdata = {32'd0, step_q};
			REG_HSS:   prdata = {16'd0, hss_q};
			default:   prdata = '0;
		endcase
	end

	assign cfg = '{alpha: alpha_q, beta: beta_q, gamma: gamma_q, step: step_q, hss: hss_q};

endmodule

`default_nettype wire

// ===== sv/abg_seq.sv =====
// Sub-step sequencer: walks the six multiply-accumulate terms per sub-step.
`default_nettype none

module abg_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	output abg_pkg::ctrl_t      ctrl
);
	import abg_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ERR,
		S_TERM,
		S_WRAP,
		S_DONE
	} state_t;

	state_t           state_q;
	term_t            term_q;
	logic [1:0]       ph_q;
	logic [SUB_W-1:0] sub_q;
	logic             fin_v_q;
	term_t            fin_term_q;
	logic             out_valid_q;
	logic             out_free;
	logic             last_sub;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign last_sub  = (sub_q == SUB_W'(SUB_STEPS - 1));

	// Control decode
	always_comb begin
		ctrl           = '0;
		ctrl.load_meas = (state_q == S_IDLE) && in_valid;
		ctrl.err_en    = (state_q == S_ERR);
		ctrl.mul_term  = term_q;
		ctrl.mul_hi    = (ph_q == 2'd1);
		ctrl.sum_load  = (state_q == S_TERM) && (ph_q == 2'd1);
		ctrl.sum_add   = (state_q == S_TERM) && (ph_q == 2'd2);
		ctrl.fin_en    = fin_v_q;
		ctrl.fin_term  = fin_term_q;
		ctrl.out_load  = (state_q == S_DONE) && out_free;
	end

	// State, counters, finalize pipe and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			term_q      <= T_POS;
			ph_q        <= 2'd0;
			sub_q       <= '0;
			fin_v_q     <= 1'b0;
			fin_term_q  <= T_POS;
			out_valid_q <= 1'b0;
		end else begin
			// finalize of a term runs in the cycle after its last accumulate
			fin_v_q    <= (state_q == S_TERM) && (ph_q == 2'd2);
			fin_term_q <= term_q;

			// a new result replaces a taken one in the same cycle
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sub_q   <= '0;
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					term_q  <= T_POS;
					ph_q    <= 2'd0;
					state_q <= S_TERM;
				end
				S_TERM: begin
					if (ph_q != 2'd2) begin
						ph_q <= ph_q + 2'd1;
					end else if (term_q == T_NVEL) begin
						if (last_sub) begin
							state_q <= S_WRAP;
						end else begin
							sub_q   <= sub_q + SUB_W'(1);
							state_q <= S_ERR;
						end
					end else begin
						ph_q   <= 2'd0;
						term_q <= term_t'(term_q + 3'd1);
					end
				end
				S_WRAP: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/abg_dp.sv =====
// Datapath: shared 33x32 multiplier, 81-bit accumulator, shift/add/saturate finalize.
`default_nettype none

module abg_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire abg_pkg::cfg_t      cfg,
	input  wire abg_pkg::ctrl_t     ctrl,
	input  wire logic signed [31:0] measured_position,
	output logic signed [31:0]      estimated_position,
	output logic signed [31:0]      estimated_velocity,
	output logic signed [31:0]      predicted_position,
	output logic signed [31:0]      predicted_velocity,
	output logic signed [31:0]      predicted_acceleration
);
	import abg_pkg::*;

	// Tracker state and per-sub-step working registers
	logic signed [31:0] pos_pred_q;
	logic signed [31:0] vel_pred_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] meas_q;
	logic signed [31:0] err_q;
	logic signed [31:0] est_pos_q;
	logic signed [31:0] est_vel_q;
	logic signed [33:0] part_q;
	logic signed [64:0] prod_q;
	logic signed [80:0] sum_q;

	// Output registers
	logic signed [31:0] out_pos_q;
	logic signed [31:0] out_vel_q;
	logic signed [31:0] out_ppos_q;
	logic signed [31:0] out_pvel_q;
	logic signed [31:0] out_pacc_q;

	logic [47:0]        gain;
	logic signed [32:0] chunk_s;
	logic signed [31:0] x_s;
	logic signed [64:0] prod_w;
	logic signed [80:0] prod_ext;
	logic signed [80:0] shr_w;
	logic signed [65:0] shifted;
	logic signed [33:0] base;
	logic signed [65:0] wide;
	logic signed [31:0] fin_sat;
	logic signed [65:0] err_wide;

	// Multiplier operand select
	always_comb begin
		case (ctrl.mul_term)
			T_POS:    begin gain = {8'd0, cfg.alpha};  x_s = err_q;     end
			T_VEL:    begin gain = {8'd0, cfg.beta};   x_s = err_q;     end
			T_ACC:    begin gain = {8'd0, cfg.gamma};  x_s = err_q;     end
			T_NPOS_V: begin gain = {16'd0, cfg.step};  x_s = est_vel_q; end
			T_NPOS_A: begin gain = cfg.hss;            x_s = acc_q;     end
			T_NVEL:   begin gain = {16'd0, cfg.step};  x_s = acc_q;     end
			default:  begin gain = '0;                 x_s = '0;        end
		endcase
	end

	// Low 32 bits of the gain first, then the high 16
	assign chunk_s  = ctrl.mul_hi ? $signed({17'd0, gain[47:32]}) : $signed({1'b0, gain[31:0]});
	assign prod_w   = chunk_s * x_s;
	assign prod_ext = {{16{prod_q[64]}}, prod_q};

	// Finalize: floor shift, add base, saturate (the partial sum keeps the unsaturated value)
	always_comb begin
		case (ctrl.fin_term) inside
			T_POS, T_VEL, T_ACC: shr_w = sum_q >>> 16;
			T_NPOS_A:            shr_w = sum_q >>> 48;
			default:             shr_w = sum_q >>> 32;
		endcase
		case (ctrl.fin_term)
			T_POS:    base = {{2{pos_pred_q[31]}}, pos_pred_q};
			T_VEL:    base = {{2{vel_pred_q[31]}}, vel_pred_q};
			T_ACC:    base = {{2{acc_q[31]}}, acc_q};
			T_NPOS_V: base = {{2{est_pos_q[31]}}, est_pos_q};
			T_NPOS_A: base = part_q;
			T_NVEL:   base = {{2{est_vel_q[31]}}, est_vel_q};
			default:  base = '0;
		endcase
	end

	assign shifted  = shr_w[65:0];
	assign wide     = {{32{base[33]}}, base} + shifted;
	assign fin_sat  = sat32(wide);
	assign err_wide = 66'(meas_q) - 66'(pos_pred_q);

	// Tracker state (cleared by reset)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_pred_q <= '0;
			vel_pred_q <= '0;
			acc_q      <= '0;
		end else if (ctrl.fin_en) begin
			case (ctrl.fin_term)
				T_ACC:    acc_q      <= fin_sat;
				T_NPOS_A: pos_pred_q <= fin_sat;
				T_NVEL:   vel_pred_q <= fin_sat;
				default: ;
			endcase
		end
	end

	// Working registers, multiplier and accumulator
	always_ff @(posedge clk) begin
		if (ctrl.load_meas) begin
			meas_q <= measured_position;
		end
		if (ctrl.err_en) begin
			err_q <= sat32(err_wide);
		end
		prod_q <= prod_w;
		if (ctrl.sum_load) begin
			sum_q <= prod_ext;
		end else if (ctrl.sum_add) begin
			sum_q <= sum_q + (prod_ext <<< 32);
		end
		if (ctrl.fin_en) begin
			case (ctrl.fin_term)
				T_POS: begin
					est_pos_q <= fin_sat;
					meas_q    <= fin_sat;
				end
				T_VEL:    est_vel_q <= fin_sat;
				T_NPOS_V: part_q    <= wide[33:0];
				default: ;
			endcase
		end
		if (ctrl.out_load) begin
			out_pos_q  <= est_pos_q;
			out_vel_q  <= est_vel_q;
			out_ppos_q <= pos_pred_q;
			out_pvel_q <= vel_pred_q;
			out_pacc_q <= acc_q;
		end
	end

	assign estimated_position     = out_pos_q;
	assign estimated_velocity     = out_vel_q;
	assign predicted_position     = out_ppos_q;
	assign predicted_velocity     = out_pvel_q;
	assign predicted_acceleration = out_pacc_q;

endmodule

`default_nettype wire

// ===== bench/abg_track_checker.sv =====
// Checker for the alpha-beta-gamma tracker: snoops the channels and the register port, predicts results and compares them.
`default_nettype none

module abg_track_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic                                in_stall,
	input  wire logic signed [31:0]                  measured_position,
	input  wire logic                                out_valid,
	input  wire logic                                out_stall,
	input  wire logic signed [31:0]                  estimated_position,
	input  wire logic signed [31:0]                  estimated_velocity,
	input  wire logic signed [31:0]                  predicted_position,
	input  wire logic signed [31:0]                  predicted_velocity,
	input  wire logic signed [31:0]                  predicted_acceleration,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [abg_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [abg_pkg::PDATA_W-1:0]         pwdata,
	input  wire logic [abg_pkg::PDATA_W-1:0]         prdata,
	input  wire logic                                pready,
	output int                                       fail_count,
	output int                                       pending
);

	import abg_pkg::*;

	// Register slot sits above the byte offset within a 64-bit word
	localparam int SLOT_LSB = 3;

	localparam logic signed [95:0] Q_TOP    = 96'sd2147483647;
	localparam logic signed [95:0] Q_BOTTOM = -96'sd2147483648;

	// One result beat
	typedef struct packed {
		logic signed [31:0] est_pos;
		logic signed [31:0] est_vel;
		logic signed [31:0] pred_pos;
		logic signed [31:0] pred_vel;
		logic signed [31:0] pred_acc;
	} track_beat_t;

	// Local copy of the gains and of the tracking state
	cfg_t               gains;
	logic signed [31:0] pos_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] acc_q;

	track_beat_t        track_q[$];
	int                 mismatches;

	assign fail_count = mismatches;

	function automatic logic signed [95:0] wide(input logic signed [31:0] v);
		return v;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
		logic signed [31:0] r;
		if (v > Q_TOP) begin
			r = Q_TOP[31:0];
		end else if (v < Q_BOTTOM) begin
			r = Q_BOTTOM[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// floor(g * x / 2^s), exact product
	function automatic logic signed [95:0] scaled_product(input logic [47:0] g,
			input logic signed [31:0] x, input int s);
		logic signed [95:0] gs;
		logic signed [95:0] xs;
		logic signed [95:0] p;
		gs = g;
		xs = x;
		p = gs * xs;
		return p >>> s;
	endfunction

	// Run all sub-steps for one sample; advances the tracking state
	function automatic track_beat_t track_sample(input logic signed [31:0] meas);
		track_beat_t        r;
		logic signed [31:0] m;
		logic signed [31:0] err;
		logic signed [31:0] ep;
		logic signed [31:0] ev;
		logic signed [31:0] ea;
		ep = pos_q;
		ev = vel_q;
		ea = acc_q;
		m = meas;
		for (int i = 0; i < SUB_STEPS; i++) begin
			err = clamp32(wide(m) - wide(pos_q));
			ep = clamp32(wide(pos_q) + scaled_product(gains.alpha, err, 16));
			ev = clamp32(wide(vel_q) + scaled_product(gains.beta, err, 16));
			ea = clamp32(wide(acc_q) + scaled_product(gains.gamma, err, 16));
			m = ep;
			pos_q = clamp32(wide(ep) + scaled_product(gains.step, ev, 32)
				+ scaled_product(gains.hss, ea, 48));
			vel_q = clamp32(wide(ev) + scaled_product(gains.step, ea, 32));
			acc_q = ea;
		end
		r.est_pos = ep;
		r.est_vel = ev;
		r.pred_pos = pos_q;
		r.pred_vel = vel_q;
		r.pred_acc = acc_q;
		return r;
	endfunction

	function automatic int field_differs(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	// Watch register port, result beats and sample beats
	always @(posedge clk or negedge arst_n) begin
		logic [2:0]   slot;
		logic [63:0]  reg_val;
		logic         known;
		track_beat_t  want;
		int           bad;
		if (!arst_n) begin
			gains.alpha = ALPHA_RST;
			gains.beta = BETA_RST;
			gains.gamma = GAMMA_RST;
			gains.step = STEP_RST;
			gains.hss = HSS_RST;
			pos_q = '0;
			vel_q = '0;
			acc_q = '0;
			track_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			// register access phase
			if (psel && penable && pready) begin
				slot = paddr[PADDR_W-1:SLOT_LSB];
				if (pwrite) begin
					case (slot)
						REG_ALPHA: gains.alpha = pwdata[39:0];
						REG_BETA:  gains.beta = pwdata[39:0];
						REG_GAMMA: gains.gamma = pwdata[39:0];
						REG_STEP:  gains.step = pwdata[31:0];
						REG_HSS:   gains.hss = pwdata[47:0];
						default: ;
					endcase
				end else begin
					known = 1'b1;
					case (slot)
						REG_ALPHA: reg_val = 64'(gains.alpha);
						REG_BETA:  reg_val = 64'(gains.beta);
						REG_GAMMA: reg_val = 64'(gains.gamma);
						REG_STEP:  reg_val = 64'(gains.step);
						REG_HSS:   reg_val = 64'(gains.hss);
						default: begin
							known = 1'b0;
							reg_val = '0;
						end
					endcase
					if (known && prdata !== reg_val) begin
						$display("%0t: register %0d read expected %h got %h",
							$time, slot, reg_val, prdata);
						mismatches++;
					end
				end
			end
			// result beat, matched against the oldest expectation
			if (out_valid && !out_stall) begin
				if (track_q.size() == 0) begin
					$display("%0t: result beat with none expected, got %h %h %h %h %h",
						$time, estimated_position, estimated_velocity,
						predicted_position, predicted_velocity, predicted_acceleration);
					mismatches++;
				end else begin
					want = track_q.pop_front();
					bad = field_differs("estimated_position", want.est_pos, estimated_position)
						+ field_differs("estimated_velocity", want.est_vel, estimated_velocity)
						+ field_differs("predicted_position", want.pred_pos, predicted_position)
						+ field_differs("predicted_velocity", want.pred_vel, predicted_velocity)
						+ field_differs("predicted_acceleration", want.pred_acc,
							predicted_acceleration);
					if (bad != 0) begin
						mismatches++;
					end
				end
			end
			// sample beat
			if (in_valid && !in_stall) begin
				track_q.push_back(track_sample(measured_position));
			end
			pending <= track_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_alpha_beta_gamma_tracker.sv =====
// Testbench top for the alpha-beta-gamma tracker: clock, reset, stimulus and verdict.
`default_nettype none

module tb_alpha_beta_gamma_tracker;

	import abg_pkg::*;

	localparam int ITEMS_PER_PHASE = 366;
	localparam int LONG_HOLD       = 1500;
	localparam int HOLD_AFTER      = 300;
	localparam int SETTLE_CYCLES   = 200;
	localparam int RUN_LIMIT       = 50_000_000;

	// Slots past the last register; writes there are dropped
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam int         REG_SLOTS       = 8;

	typedef enum {
		GAINS_DEFAULT,
		GAINS_MAX,
		GAINS_ZERO,
		GAINS_TUNED,
		GAINS_WILD
	} gain_set_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [31:0]        measured_position = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [31:0]        estimated_position;
	logic signed [31:0]        estimated_velocity;
	logic signed [31:0]        predicted_position;
	logic signed [31:0]        predicted_velocity;
	logic signed [31:0]        predicted_acceleration;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [PADDR_W-1:0]        paddr = '0;
	logic [PDATA_W-1:0]        pwdata = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;
	int                        fail_count;
	int                        pending;
	int                        results_taken = 0;
	int                        traj_pos;
	int                        traj_vel;

	logic signed [31:0] corners[12] = '{32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
		32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_FFFF,
		32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0000};
	logic signed [31:0] overflow_vals[5] = '{32'sh7FFF_FFFF, 32'sh8000_0000,
		32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh8000_0000};
	logic signed [31:0] still_vals[4] = '{32'sh1234_5678, 32'sh8000_0000,
		32'sh7FFF_FFFF, 32'shFFFF_FFFF};
	gain_set_t          phase_gains[5] = '{GAINS_DEFAULT, GAINS_TUNED, GAINS_WILD,
		GAINS_TUNED, GAINS_DEFAULT};

	alpha_beta_gamma_tracker dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.measured_position      (measured_position),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.estimated_position     (estimated_position),
		.estimated_velocity     (estimated_velocity),
		.predicted_position     (predicted_position),
		.predicted_velocity     (predicted_velocity),
		.predicted_acceleration (predicted_acceleration),
		.psel                   (psel),
		.penable                (penable),
		.pwrite                 (pwrite),
		.paddr                  (paddr),
		.pwdata                 (pwdata),
		.prdata                 (prdata),
		.pready                 (pready)
	);

	abg_track_checker u_chk (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.measured_position      (measured_position),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.estimated_position     (estimated_position),
		.estimated_velocity     (estimated_velocity),
		.predicted_position     (predicted_position),
		.predicted_velocity     (predicted_velocity),
		.predicted_acceleration (predicted_acceleration),
		.psel                   (psel),
		.penable                (penable),
		.pwrite                 (pwrite),
		.paddr                  (paddr),
		.pwdata                 (pwdata),
		.prdata                 (prdata),
		.pready                 (pready),
		.fail_count             (fail_count),
		.pending                (pending)
	);

	always #4 clk = ~clk;

	// Count result beats taken, drives the long hold below
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			results_taken <= results_taken + 1;
		end
	end

	// Offer one sample and hold it until the beat is taken
	task automatic send_sample(input logic signed [31:0] v);
		in_valid <= 1'b1;
		measured_position <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering and wait for every expected result
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [2:0] slot, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {slot, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_back_all();
		for (int i = REG_ALPHA; i <= REG_HSS; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {3'(i), 3'b000};
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			psel <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Program a gain set, poke the spare slots, then read the gain registers back
	task automatic load_gains(input gain_set_t set);
		logic [63:0] val[5];
		case (set)
			GAINS_DEFAULT: begin
				val[REG_ALPHA] = 64'(ALPHA_RST);
				val[REG_BETA]  = 64'(BETA_RST);
				val[REG_GAMMA] = 64'(GAMMA_RST);
				val[REG_STEP]  = 64'(STEP_RST);
				val[REG_HSS]   = 64'(HSS_RST);
			end
			GAINS_MAX: begin
				for (int i = 0; i < 5; i++) val[i] = '1;
			end
			GAINS_ZERO: begin
				for (int i = 0; i < 5; i++) val[i] = '0;
			end
			GAINS_TUNED: begin
				val[REG_ALPHA] = 64'($urandom_range(0, 1 << 17));
				val[REG_BETA]  = 64'($urandom_range(0, 1 << 24));
				val[REG_GAMMA] = 64'($urandom_range(0, 1 << 30));
				val[REG_STEP]  = 64'($urandom >> $urandom_range(4, 16));
				val[REG_HSS]   = {$urandom, $urandom} >> $urandom_range(16, 40);
			end
			default: begin
				for (int i = 0; i < 5; i++) val[i] = {$urandom, $urandom};
			end
		endcase
		for (int i = REG_ALPHA; i <= REG_HSS; i++) begin
			write_reg(3'(i), val[i]);
		end
		for (int i = REG_SPARE_FIRST; i < REG_SLOTS; i++) begin
			write_reg(3'(i), {$urandom, $urandom});
		end
		read_back_all();
	endtask

	// Random samples: mostly a smooth noisy trajectory, some noise, some near zero
	task automatic run_items(input int count);
		int                 gap;
		int                 r;
		logic signed [31:0] v;
		traj_pos = $urandom;
		traj_vel = 0;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				traj_vel += int'($urandom_range(0, 8191)) - 4096;
				traj_pos += traj_vel;
				v = traj_pos + int'($urandom_range(0, 2047)) - 1024;
			end else if (r < 80) begin
				v = $urandom;
			end else begin
				v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
			end
			send_sample(v);
			// idle between beats, with stretches of back-to-back offers
			r = $urandom_range(0, 99);
			if ((k / 64) % 4 == 1 || r < 50) begin
				gap = 0;
			end else if (r < 85) begin
				gap = $urandom_range(1, 3);
			end else if (r < 97) begin
				gap = $urandom_range(4, 20);
			end else begin
				gap = $urandom_range(21, 250);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Result side: random stalls, open stretches, and one long hold
	initial begin
		int  r;
		bit  held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (!held && results_taken >= HOLD_AFTER) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (r < 8) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(100, 600)) @(posedge clk);
			end else if (r < 55) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else if (r < 96) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(20, 250)) @(posedge clk);
			end
		end
	end

	// Main sequence
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, then corner samples with the default gains
		read_back_all();
		foreach (corners[i]) send_sample(corners[i]);
		drain_results();

		// everything at full scale: saturation throughout
		load_gains(GAINS_MAX);
		foreach (overflow_vals[i]) send_sample(overflow_vals[i]);
		drain_results();

		// zero gains and interval: state must hold still
		load_gains(GAINS_ZERO);
		foreach (still_vals[i]) send_sample(still_vals[i]);
		drain_results();

		foreach (phase_gains[p]) begin
			load_gains(phase_gains[p]);
			run_items(ITEMS_PER_PHASE);
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#RUN_LIMIT;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

// ===== alpha_beta_gamma_tracker.f =====
sv/abg_pkg.sv
sv/abg_regs.sv
sv/abg_seq.sv
sv/abg_dp.sv
sv/alpha_beta_gamma_tracker.sv
bench/abg_track_checker.sv
bench/tb_alpha_beta_gamma_tracker.sv
